FILE: hw/rtl/hcb_pkg.sv
package hcb_pkg;

  localparam int MAX_LEAVES  = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int SYM_W   = 8;
  localparam int WIN_W   = 16;
  localparam int CODE_W  = 63;
  localparam int CLEN_W  = 6;

  localparam int NODE_W     = $clog2(2 * MAX_LEAVES);
  localparam int NODE_SLOTS = 1 << NODE_W;
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int LEAF_AW    = $clog2(MAX_LEAVES);
  localparam int NWT_W      = WEIGHT_BITS + $clog2(MAX_LEAVES);
  localparam int KEPT_W     = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_SCAN,
    ST_MERGE_A,
    ST_MERGE_B,
    ST_WALK,
    ST_CLIMB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic merge_a;
    logic merge_b;
    logic emit_start;
    logic climb;
    logic next_leaf;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic single_leaf;
    logic scan_done;
    logic last_merge;
    logic has_parent;
    logic last_code;
  } status_t;

endpackage

FILE: hw/rtl/hcb_leaf_if.sv
interface hcb_leaf_if
  import hcb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic [WIN_W-1:0] weight;
  logic             last_leaf;

  modport source (output valid, symbol, weight, last_leaf, input ready);
  modport sink (input valid, symbol, weight, last_leaf, output ready);
endinterface

FILE: hw/rtl/hcb_code_if.sv
interface hcb_code_if
  import hcb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  code_symbol;
  logic [CODE_W-1:0] code_bits;
  logic [CLEN_W-1:0] code_length;
  logic              last_code;

  modport source (output valid, code_symbol, code_bits, code_length, last_code, input ready);
  modport sink (input valid, code_symbol, code_bits, code_length, last_code, output ready);
endinterface

FILE: hw/rtl/hcb_ram.sv
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/hcb_ctrl.sv
module hcb_ctrl
  import hcb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        if (status.single_leaf) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_WALK;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) state_next = ST_MERGE_A;
      end
      ST_MERGE_A: begin
        cmd.merge_a = 1'b1;
        state_next  = ST_MERGE_B;
      end
      ST_MERGE_B: begin
        cmd.merge_b = 1'b1;
        if (status.last_merge) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_WALK;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_WALK: begin
        state_next = status.has_parent ? ST_CLIMB : ST_OUT;
      end
      ST_CLIMB: begin
        cmd.climb  = 1'b1;
        state_next = ST_WALK;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last_code) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.next_leaf = 1'b1;
            state_next    = ST_WALK;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule

FILE: hw/rtl/hcb_datapath.sv
module hcb_datapath
  import hcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [WIN_W-1:0]  weight,
  output logic [SYM_W-1:0]  code_symbol,
  output logic [CODE_W-1:0] code_bits,
  output logic [CLEN_W-1:0] code_length,
  output logic              last_code
);
  logic [CNT_W-1:0]      count;
  logic [NODE_SLOTS-1:0] has_par;
  logic [NODE_W-1:0]     node_i, scan_j, scan_jd, p1, p2, cur;
  logic [NWT_W-1:0]      m1, m2;
  logic                  have1, have2, pend;
  logic [CNT_W-1:0]      k;
  logic [CODE_W-1:0]     bits;
  logic [CLEN_W-1:0]     len;

  logic              wt_we;
  logic [NODE_W-1:0] wt_waddr;
  logic [NWT_W-1:0]  wt_wdata, wt_rdata;
  logic              par_we;
  logic [NODE_W-1:0] par_waddr;
  logic [NODE_W:0]   par_wdata, par_rdata;
  logic              room;
  logic              j_live;
  logic [NODE_W:0]   total, i_plus;

  assign room   = count < CNT_W'(MAX_LEAVES);
  assign j_live = scan_j < node_i;
  assign total  = (NODE_W + 1)'({count, 1'b0}) - (NODE_W + 1)'(1);
  assign i_plus = {1'b0, node_i} + (NODE_W + 1)'(1);

  assign wt_we    = (cmd.load && room) || cmd.merge_a;
  assign wt_waddr = cmd.merge_a ? node_i : NODE_W'(count);
  assign wt_wdata = cmd.merge_a ? (m1 + m2) : NWT_W'(weight[KEPT_W-1:0]);

  assign par_we    = cmd.merge_a || cmd.merge_b;
  assign par_waddr = cmd.merge_a ? p1 : p2;
  assign par_wdata = {node_i, cmd.merge_b};

  hcb_ram #(.WIDTH(NWT_W), .DEPTH(NODE_SLOTS)) u_weight (
    .clk, .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .raddr(scan_j), .rdata(wt_rdata)
  );

  hcb_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODE_SLOTS)) u_parent (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(cur), .rdata(par_rdata)
  );

  hcb_ram #(.WIDTH(SYM_W), .DEPTH(1 << LEAF_AW)) u_symbol (
    .clk, .we(cmd.load && room), .waddr(count[LEAF_AW-1:0]), .wdata(symbol),
    .raddr(k[LEAF_AW-1:0]), .rdata(code_symbol)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      has_par <= '0;
    end else if (cmd.clear) begin
      count   <= '0;
      has_par <= '0;
    end else begin
      if (cmd.load && room) count <= count + CNT_W'(1);
      if (cmd.merge_a) has_par[p1] <= 1'b1;
      if (cmd.merge_b) has_par[p2] <= 1'b1;
    end
  end

  // merge scan: one node read per cycle, compare in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.prep || cmd.merge_b) begin
      if (cmd.prep) node_i <= NODE_W'(count);
      else          node_i <= node_i + NODE_W'(1);
      scan_j <= '0;
      pend   <= 1'b0;
      have1  <= 1'b0;
      have2  <= 1'b0;
    end else if (cmd.scan) begin
      pend    <= j_live && !has_par[scan_j];
      scan_jd <= scan_j;
      if (j_live) scan_j <= scan_j + NODE_W'(1);
      if (pend) begin
        if (!have1 || wt_rdata < m1) begin
          p2    <= p1;
          m2    <= m1;
          have2 <= have1;
          p1    <= scan_jd;
          m1    <= wt_rdata;
          have1 <= 1'b1;
        end else if (!have2 || wt_rdata < m2) begin
          p2    <= scan_jd;
          m2    <= wt_rdata;
          have2 <= 1'b1;
        end
      end
    end
  end

  // code walk from leaf to root
  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      k    <= '0;
      cur  <= '0;
      bits <= '0;
      len  <= '0;
    end else if (cmd.next_leaf) begin
      k    <= k + CNT_W'(1);
      cur  <= NODE_W'(k) + NODE_W'(1);
      bits <= '0;
      len  <= '0;
    end else if (cmd.climb) begin
      bits <= bits | (CODE_W'(par_rdata[0]) << len);
      len  <= len + CLEN_W'(1);
      cur  <= par_rdata[NODE_W:1];
    end
  end

  assign status.single_leaf = count == CNT_W'(1);
  assign status.scan_done   = !j_live && !pend;
  assign status.last_merge  = i_plus == total;
  assign status.has_parent  = has_par[cur];
  assign status.last_code   = last_code;

  assign last_code   = (k + CNT_W'(1)) == count;
  assign code_bits   = bits;
  assign code_length = len;
endmodule

FILE: hw/rtl/huffman_code_builder_core.sv
// Channel | Dir | Fields                                        | Transfer
// leaf    | in  | symbol, weight, last_leaf                     | valid && ready
// code    | out | code_symbol, code_bits, code_length, last_code | valid && ready
//
// Loading accepts a leaf whenever one is offered; extra leaves past MAX_LEAVES are dropped.
// A prep state follows the closing leaf. Merge i (i = n..2n-2) then scans the
// nodes below i for the two lightest free ones (one node weight read per cycle,
// then the last compare), and its merge A and merge B states write the links.
// Each code climbs from its leaf to the root, reading the parent RAM per level.
// Reset clears the leaf count and all parent valid bits.
// Leaves are refused while a set is building or emitting; a stalled code holds.
module huffman_code_builder_core
  import hcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hcb_leaf_if.sink   leaf,
  hcb_code_if.source code
);
  cmd_t    cmd;
  status_t status;

  // FSM sequences load, merge scans and code walks
  hcb_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid (leaf.valid),
    .in_last  (leaf.last_leaf),
    .in_ready (leaf.ready),
    .out_valid(code.valid),
    .out_ready(code.ready),
    .cmd,
    .status
  );

  // node tables, min search and code accumulation
  hcb_datapath u_dp (
    .clk,
    .rst,
    .cmd,
    .status,
    .symbol     (leaf.symbol),
    .weight     (leaf.weight),
    .code_symbol(code.code_symbol),
    .code_bits  (code.code_bits),
    .code_length(code.code_length),
    .last_code  (code.last_code)
  );
endmodule

FILE: verif/tb_huffman_code_builder_core.sv
module tb_huffman_code_builder_core;
  import hcb_pkg::*;

  // One leaf as offered on the leaf channel.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [WIN_W-1:0] weight;
    logic             last_leaf;
  } leaf_item_t;

  // One code as expected on the code channel.
  typedef struct packed {
    logic [SYM_W-1:0]  code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [CLEN_W-1:0] code_length;
    logic              last_code;
  } code_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcb_leaf_if leaf ();
  hcb_code_if code ();

  huffman_code_builder_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .leaf (leaf.sink),
    .code (code.source)
  );

  always #4 clk = ~clk;

  // Leaves still to be offered, and codes still to arrive.
  leaf_item_t leaves_pending[$];
  code_item_t codes_expected[$];
  int         fail_count = 0;

  // Shadow of the tree builder's tables.
  logic [NWT_W-1:0]  tree_weight[2*MAX_LEAVES];
  int                tree_parent[2*MAX_LEAVES];
  bit                tree_linked[2*MAX_LEAVES];
  int                tree_left[2*MAX_LEAVES];
  int                tree_right[2*MAX_LEAVES];
  logic [SYM_W-1:0]  held_symbol[MAX_LEAVES];
  int                held_count = 0;

  // Merge the n held leaves into a tree, lowest weights first, lower index on ties.
  function automatic void merge_leaves(int n);
    int i, j, p1, p2;
    bit have1, have2;
    logic [NWT_W-1:0] m1, m2;
    for (i = n; i < 2*n-1; i++) begin
      have1 = 0; have2 = 0; p1 = 0; p2 = 0; m1 = '0; m2 = '0;
      for (j = 0; j < i; j++) begin
        if (tree_linked[j]) continue;
        if (!have1 || tree_weight[j] < m1) begin
          p2 = p1; m2 = m1; have2 = have1;
          p1 = j; m1 = tree_weight[j]; have1 = 1;
        end else if (!have2 || tree_weight[j] < m2) begin
          p2 = j; m2 = tree_weight[j]; have2 = 1;
        end
      end
      if (!have2) break;
      tree_left[i] = p1;
      tree_right[i] = p2;
      tree_weight[i] = m1 + m2;
      tree_parent[p1] = i;
      tree_parent[p2] = i;
      tree_linked[p1] = 1;
      tree_linked[p2] = 1;
    end
  endfunction

  // Absorb one accepted leaf; on the closing leaf, queue the code of every held leaf.
  function automatic void predict_codes(leaf_item_t it);
    int k, cur, up, len;
    logic [CODE_W-1:0] bits;
    code_item_t c;
    if (held_count < MAX_LEAVES) begin
      held_symbol[held_count] = it.symbol;
      tree_weight[held_count] = NWT_W'(it.weight[KEPT_W-1:0]);
      tree_linked[held_count] = 0;
      held_count++;
    end
    if (!it.last_leaf) return;
    merge_leaves(held_count);
    for (k = 0; k < held_count; k++) begin
      cur = k; len = 0; bits = '0;
      while (tree_linked[cur] && len < 63) begin
        up = tree_parent[cur];
        if (tree_right[up] == cur && tree_left[up] != cur) bits[len] = 1'b1;
        len++;
        cur = up;
      end
      c.code_symbol = held_symbol[k];
      c.code_bits   = bits;
      c.code_length = CLEN_W'(len);
      c.last_code   = (k + 1 == held_count);
      codes_expected.push_back(c);
    end
    held_count = 0;
    for (k = 0; k < 2*MAX_LEAVES; k++) tree_linked[k] = 0;
  endfunction

  function automatic leaf_item_t make_leaf(int sym, int wt, bit last);
    leaf_item_t it;
    it.symbol = SYM_W'(sym);
    it.weight = WIN_W'(wt);
    it.last_leaf = last;
    return it;
  endfunction

  // Queue a whole set of n leaves; wmax bounds the random weights.
  task automatic queue_set(int n, int wmax);
    for (int k = 0; k < n; k++)
      leaves_pending.push_back(make_leaf($urandom_range(0, 255), $urandom_range(0, wmax),
                                         k == n - 1));
  endtask

  // Count leaf transfers at the rising edge, where they happen.
  int in_xfers = 0;
  int offers   = 0;

  always @(posedge clk) begin
    if (!rst && leaf.valid && leaf.ready) begin
      predict_codes(leaves_pending.pop_front());
      in_xfers <= in_xfers + 1;
    end
  end

  // Driver: offer leaves in bursts with random gaps, change inputs on the falling edge.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      leaf.valid <= 1'b0;
    end else begin
      if (leaves_pending.size() == 0) begin
        leaf.valid <= 1'b0;
      end else if (leaf.valid && in_xfers != offers) begin
        // hold the current offer until it transfers
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        leaf.valid <= 1'b0;
      end else begin
        leaf.valid     <= 1'b1;
        leaf.symbol    <= leaves_pending[0].symbol;
        leaf.weight    <= leaves_pending[0].weight;
        leaf.last_leaf <= leaves_pending[0].last_leaf;
        offers         <= offers + 1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Receiver: a stall pattern of its own, plus one long hold-off while leaves are still on offer.
  int  stall_phase = 0;
  int  hold_off    = 0;
  bit  hold_armed  = 1'b1;

  always @(negedge clk) begin
    if (rst) begin
      code.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      code.ready <= 1'b0;
    end else if (hold_armed && code.valid) begin
      hold_armed <= 1'b0;
      hold_off   <= 400;
      code.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 23;
      // alternate a busy stretch, a steady stretch and a random one
      if (stall_phase < 6) code.ready <= stall_phase[0];
      else if (stall_phase < 14) code.ready <= 1'b1;
      else code.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: check each transfer against the oldest expected code.
  always @(posedge clk) begin
    code_item_t want;
    if (!rst && code.valid && code.ready) begin
      if (codes_expected.size() == 0) begin
        $display("%0t: unexpected code sym=%h bits=%h len=%0d last=%b", $time,
                 code.code_symbol, code.code_bits, code.code_length, code.last_code);
        fail_count++;
      end else begin
        want = codes_expected.pop_front();
        if (code.code_symbol !== want.code_symbol) begin
          $display("%0t: code_symbol expected %h actual %h", $time,
                   want.code_symbol, code.code_symbol);
          fail_count++;
        end
        if (code.code_bits !== want.code_bits) begin
          $display("%0t: code_bits expected %h actual %h", $time,
                   want.code_bits, code.code_bits);
          fail_count++;
        end
        if (code.code_length !== want.code_length) begin
          $display("%0t: code_length expected %0d actual %0d", $time,
                   want.code_length, code.code_length);
          fail_count++;
        end
        if (code.last_code !== want.last_code) begin
          $display("%0t: last_code expected %b actual %b", $time,
                   want.last_code, code.last_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int n;
    leaf.valid = 1'b0;
    leaf.symbol = '0;
    leaf.weight = '0;
    leaf.last_leaf = 1'b0;
    code.ready = 1'b0;

    // Directed: single leaf, equal weights, extreme weights and symbols,
    // a skewed set that makes a deep tree, and a set that overflows the table.
    leaves_pending.push_back(make_leaf(8'hFF, 16'hFFFF, 1'b1));
    leaves_pending.push_back(make_leaf(8'h00, 0, 1'b0));
    leaves_pending.push_back(make_leaf(8'h01, 0, 1'b1));
    leaves_pending.push_back(make_leaf(8'hAA, 16'hFFFF, 1'b0));
    leaves_pending.push_back(make_leaf(8'h55, 16'hFFFF, 1'b0));
    leaves_pending.push_back(make_leaf(8'hFF, 16'hFFFF, 1'b1));
    for (int k = 0; k < 12; k++)
      leaves_pending.push_back(make_leaf(k, 1 << k, k == 11));
    for (int k = 0; k < MAX_LEAVES + 3; k++)
      leaves_pending.push_back(make_leaf($urandom_range(0, 255),
                                         $urandom_range(0, 65535), k == MAX_LEAVES + 2));
    // Random sets: mostly small, a few of 20 to MAX_LEAVES leaves, weights from tiny (many ties) to full range.
    while (leaves_pending.size() < 100) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_LEAVES) : $urandom_range(1, 8);
      queue_set(n, ($urandom_range(0, 1) == 0) ? 3 : 65535);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (leaves_pending.size() == 0 && codes_expected.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && codes_expected.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
